[sv/mts_pkg.sv]
package mts_pkg;

    // accumulation limits
    localparam int MAX_RECORDS = 65535;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int SUM_W       = CNT_W + 8;

    // calendar and temperature bounds
    localparam int NMONTHS     = 12;
    localparam int MIDX_W      = $clog2(NMONTHS);
    localparam int LAST_YEAR   = 9999;
    localparam logic signed [7:0] START_LOW  = 8'sd99;
    localparam logic signed [7:0] START_HIGH = -8'sd99;

    // configuration register indexes
    localparam logic REG_EARLIEST_YEAR = 1'b0;
    localparam logic REG_TEMP_LIMIT    = 1'b1;

    typedef struct packed {
        logic [13:0] earliest_year;
        logic [6:0]  temp_limit;
    } cfg_t;

    // classified record passed from front to back
    typedef struct packed {
        logic               valid;
        logic [15:0]        line;
        logic [3:0]         month;
        logic [13:0]        year;
        logic signed [7:0]  temp;
    } item_t;

endpackage

[sv/mts_front.sv]
module mts_front
    import mts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic [13:0]       rec_year,
    input  logic [3:0]        rec_month,
    input  logic [4:0]        rec_day,
    input  logic [4:0]        rec_hour,
    input  logic [5:0]        rec_minute,
    input  logic signed [7:0] temperature,
    input  logic              fields_complete,
    output item_t             item
);

    logic [15:0]       line_reg;
    logic [15:0]       line_next;
    logic signed [8:0] t9;
    logic signed [8:0] lim9;
    logic              ok;

    // record checks
    always_comb
    begin
        t9   = 9'(temperature);
        lim9 = $signed({2'b00, cfg.temp_limit});
        ok   = fields_complete
            && (rec_year >= cfg.earliest_year) && (rec_year <= 14'(LAST_YEAR))
            && (rec_month >= 4'd1) && (rec_month <= 4'(NMONTHS))
            && (rec_day >= 5'd1)
            && (rec_hour <= 5'd23) && (rec_minute <= 6'd59)
            && (t9 >= -lim9) && (t9 <= lim9);
        item.valid = ok;
        item.line  = line_reg;
        item.month = rec_month;
        item.year  = rec_year;
        item.temp  = temperature;
        line_next  = line_reg + 16'd1;
    end

    // line counter, one step per accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= 16'd1;
        end
        else if (accept)
        begin
            line_reg <= line_next;
        end
    end

endmodule

[sv/mts_queue.sv]
module mts_queue
    import mts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    item_t      mem [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

[sv/mts_div.sv]
module mts_div
    import mts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [7:0]       quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    num_reg;
    logic [CNT_W-1:0]    dvs_reg;
    logic                neg_reg;
    logic [CNT_W:0]      trial;
    logic                fits;
    logic [SUM_W-1:0]    signed_q;

    // one restoring step per cycle
    always_comb
    begin
        trial    = {rem_reg, num_reg[SUM_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        signed_q = neg_reg ? (~num_reg + 1'b1) : num_reg;
    end

    assign done     = done_reg;
    assign quotient = (dvs_reg == '0) ? 8'sd0 : $signed(signed_q[7:0]);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, dvs_reg}) : CNT_W'(trial);
            num_reg <= {num_reg[SUM_W-2:0], fits};
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

[sv/mts_back.sv]
module mts_back
    import mts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  item_t             q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              record_valid,
    output logic [15:0]       line_number,
    output logic [3:0]        stats_month,
    output logic [13:0]       month_first_year,
    output logic signed [7:0] month_min,
    output logic signed [7:0] month_max,
    output logic signed [7:0] month_avg,
    output logic signed [7:0] year_min,
    output logic signed [7:0] year_max,
    output logic signed [7:0] year_avg,
    output logic [15:0]       valid_total
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    item_t      item_reg;

    logic signed [7:0]       mlow_reg   [NMONTHS];
    logic signed [7:0]       mhigh_reg  [NMONTHS];
    logic signed [SUM_W-1:0] msum_reg   [NMONTHS];
    logic [CNT_W-1:0]        mcnt_reg   [NMONTHS];
    logic [13:0]             myear_reg  [NMONTHS];
    logic signed [7:0]       alow_reg;
    logic signed [7:0]       ahigh_reg;
    logic signed [SUM_W-1:0] asum_reg;
    logic [CNT_W-1:0]        acnt_reg;

    // per-item result fields
    logic                    mvalid_reg;
    logic [13:0]             mfirst_reg;
    logic signed [7:0]       mmin_reg;
    logic signed [7:0]       mmax_reg;
    logic signed [SUM_W-1:0] dsum_m_reg;
    logic [CNT_W-1:0]        dcnt_m_reg;
    logic signed [SUM_W-1:0] dsum_a_reg;
    logic [CNT_W-1:0]        dcnt_a_reg;

    logic                    out_valid_reg;
    logic [15:0]             line_out_reg;
    logic [3:0]              month_out_reg;
    logic [13:0]             first_out_reg;
    logic signed [7:0]       mmin_out_reg;
    logic signed [7:0]       mmax_out_reg;
    logic signed [7:0]       mavg_out_reg;
    logic signed [7:0]       amin_out_reg;
    logic signed [7:0]       amax_out_reg;
    logic signed [7:0]       aavg_out_reg;
    logic [15:0]             total_out_reg;
    logic                    rvalid_out_reg;

    logic [MIDX_W-1:0]       m;
    logic signed [7:0]       mlow_n;
    logic signed [7:0]       mhigh_n;
    logic signed [SUM_W-1:0] msum_n;
    logic [CNT_W-1:0]        mcnt_n;
    logic [13:0]             myear_n;
    logic signed [7:0]       alow_n;
    logic signed [7:0]       ahigh_n;
    logic signed [SUM_W-1:0] asum_n;
    logic [CNT_W-1:0]        acnt_n;
    logic signed [SUM_W-1:0] t_ext;
    logic                    div_start;
    logic                    mdone;
    logic                    adone;
    logic signed [7:0]       mq;
    logic signed [7:0]       aq;

    // statistics update for the current record
    always_comb
    begin
        m       = MIDX_W'(item_reg.month - 4'd1);
        t_ext   = SUM_W'(item_reg.temp);
        mlow_n  = (item_reg.temp < mlow_reg[m]) ? item_reg.temp : mlow_reg[m];
        mhigh_n = (item_reg.temp > mhigh_reg[m]) ? item_reg.temp : mhigh_reg[m];
        myear_n = (mcnt_reg[m] == '0) ? item_reg.year : myear_reg[m];
        if (mcnt_reg[m] < CNT_W'(MAX_RECORDS))
        begin
            msum_n = msum_reg[m] + t_ext;
            mcnt_n = mcnt_reg[m] + 1'b1;
        end
        else
        begin
            msum_n = msum_reg[m];
            mcnt_n = mcnt_reg[m];
        end
        alow_n  = (item_reg.temp < alow_reg) ? item_reg.temp : alow_reg;
        ahigh_n = (item_reg.temp > ahigh_reg) ? item_reg.temp : ahigh_reg;
        if (acnt_reg < CNT_W'(MAX_RECORDS))
        begin
            asum_n = asum_reg + t_ext;
            acnt_n = acnt_reg + 1'b1;
        end
        else
        begin
            asum_n = asum_reg;
            acnt_n = acnt_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mdone && adone)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign q_pop     = (state_reg == S_IDLE) && q_not_empty;
    assign div_start = (state_reg == S_DIV);

    mts_div u_mdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dsum_m_reg),
        .divisor  (dcnt_m_reg),
        .done     (mdone),
        .quotient (mq)
    );

    mts_div u_adiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dsum_a_reg),
        .divisor  (dcnt_a_reg),
        .done     (adone),
        .quotient (aq)
    );

    // item capture and per-item figures
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_head;
        end
        if (state_reg == S_UPD)
        begin
            mvalid_reg <= item_reg.valid;
            mfirst_reg <= item_reg.valid ? myear_n : 14'd0;
            mmin_reg   <= item_reg.valid ? mlow_n : 8'sd0;
            mmax_reg   <= item_reg.valid ? mhigh_n : 8'sd0;
            dsum_m_reg <= item_reg.valid ? msum_n : '0;
            dcnt_m_reg <= item_reg.valid ? mcnt_n : '0;
            dsum_a_reg <= item_reg.valid ? asum_n : asum_reg;
            dcnt_a_reg <= item_reg.valid ? acnt_n : acnt_reg;
        end
        if (state_reg == S_WAIT && mdone && adone)
        begin
            rvalid_out_reg <= mvalid_reg;
            line_out_reg   <= item_reg.line;
            month_out_reg  <= mvalid_reg ? item_reg.month : 4'd0;
            first_out_reg  <= mfirst_reg;
            mmin_out_reg   <= mmin_reg;
            mmax_out_reg   <= mmax_reg;
            mavg_out_reg   <= mq;
            amin_out_reg   <= alow_reg;
            amax_out_reg   <= ahigh_reg;
            aavg_out_reg   <= aq;
            total_out_reg  <= 16'(acnt_reg);
        end
    end

    // state and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NMONTHS; i++)
            begin
                mlow_reg[i]  <= START_LOW;
                mhigh_reg[i] <= START_HIGH;
                msum_reg[i]  <= '0;
                mcnt_reg[i]  <= '0;
                myear_reg[i] <= 14'd0;
            end
            alow_reg  <= START_LOW;
            ahigh_reg <= START_HIGH;
            asum_reg  <= '0;
            acnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= (state_next == S_OUT);
            if (state_reg == S_UPD && item_reg.valid)
            begin
                mlow_reg[m]  <= mlow_n;
                mhigh_reg[m] <= mhigh_n;
                msum_reg[m]  <= msum_n;
                mcnt_reg[m]  <= mcnt_n;
                myear_reg[m] <= myear_n;
                alow_reg     <= alow_n;
                ahigh_reg    <= ahigh_n;
                asum_reg     <= asum_n;
                acnt_reg     <= acnt_n;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign record_valid     = rvalid_out_reg;
    assign line_number      = line_out_reg;
    assign stats_month      = month_out_reg;
    assign month_first_year = first_out_reg;
    assign month_min        = mmin_out_reg;
    assign month_max        = mmax_out_reg;
    assign month_avg        = mavg_out_reg;
    assign year_min         = amin_out_reg;
    assign year_max         = amax_out_reg;
    assign year_avg         = aavg_out_reg;
    assign valid_total      = total_out_reg;

    // checks
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        acnt_reg <= CNT_W'(MAX_RECORDS))
        else $error("overall count beyond limit");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped while busy");

    a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_WAIT && $past(mdone && adone))
        else $error("result shown before averages done");

endmodule

[sv/monthly_temperature_statistics.sv]
// monthly temperature statistics
//
// input channel: one record per transfer (year, month, day, hour, minute,
// temperature, fields_complete), taken when in_valid is high and in_stall
// low. each record is checked, given a line number and put in a two-entry
// queue; in_stall is high only while that queue is full.
// output channel: one result per record, in order, taken when out_valid is
// high and out_stall low. the result holds while stalled.
// from a record leaving the head of the queue to its result showing on
// out_valid, the path is an update state, a start state, then two restoring
// dividers run side by side for the month and overall averages, one
// quotient bit per cycle over the 24-bit sum width, and a load step. a
// record leaves the queue only once the result before it has been taken.
// configuration: earliest_year at address 0, temp_limit at address 4,
// written over the apb port while the block is idle.
// reset: all statistics return to their start values (min 99, max -99,
// sums and counts zero), the line number restarts at 1 and the
// registers return to 1972 and 99.
module monthly_temperature_statistics
    import mts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [13:0]       rec_year,
    input  logic [3:0]        rec_month,
    input  logic [4:0]        rec_day,
    input  logic [4:0]        rec_hour,
    input  logic [5:0]        rec_minute,
    input  logic signed [7:0] temperature,
    input  logic              fields_complete,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              record_valid,
    output logic [15:0]       line_number,
    output logic [3:0]        stats_month,
    output logic [13:0]       month_first_year,
    output logic signed [7:0] month_min,
    output logic signed [7:0] month_max,
    output logic signed [7:0] month_avg,
    output logic signed [7:0] year_min,
    output logic signed [7:0] year_max,
    output logic signed [7:0] year_avg,
    output logic [15:0]       valid_total
);

    cfg_t  cfg_reg;
    logic  wr_en;
    logic  q_full;
    logic  accept;
    logic  q_pop;
    logic  q_not_empty;
    item_t front_item;
    item_t q_head;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.earliest_year <= 14'd1972;
            cfg_reg.temp_limit    <= 7'd99;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_EARLIEST_YEAR)
            begin
                cfg_reg.earliest_year <= pwdata[13:0];
            end
            else
            begin
                cfg_reg.temp_limit <= pwdata[6:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_TEMP_LIMIT)
        begin
            prdata = {25'd0, cfg_reg.temp_limit};
        end
        else
        begin
            prdata = {18'd0, cfg_reg.earliest_year};
        end
    end

    // input transfer
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    mts_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .accept          (accept),
        .rec_year        (rec_year),
        .rec_month       (rec_month),
        .rec_day         (rec_day),
        .rec_hour        (rec_hour),
        .rec_minute      (rec_minute),
        .temperature     (temperature),
        .fields_complete (fields_complete),
        .item            (front_item)
    );

    mts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mts_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_not_empty      (q_not_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .record_valid     (record_valid),
        .line_number      (line_number),
        .stats_month      (stats_month),
        .month_first_year (month_first_year),
        .month_min        (month_min),
        .month_max        (month_max),
        .month_avg        (month_avg),
        .year_min         (year_min),
        .year_max         (year_max),
        .year_avg         (year_avg),
        .valid_total      (valid_total)
    );

endmodule

[dv/tb_monthly_temperature_statistics.sv]
`timescale 1ns / 100ps

module tb_monthly_temperature_statistics;
    import mts_pkg::*;

    // clock, reset and ports
    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [13:0]       rec_year;
    logic [3:0]        rec_month;
    logic [4:0]        rec_day;
    logic [4:0]        rec_hour;
    logic [5:0]        rec_minute;
    logic signed [7:0] temperature;
    logic              fields_complete;
    logic              out_valid;
    logic              out_stall;
    logic              record_valid;
    logic [15:0]       line_number;
    logic [3:0]        stats_month;
    logic [13:0]       month_first_year;
    logic signed [7:0] month_min;
    logic signed [7:0] month_max;
    logic signed [7:0] month_avg;
    logic signed [7:0] year_min;
    logic signed [7:0] year_max;
    logic signed [7:0] year_avg;
    logic [15:0]       valid_total;

    typedef struct {
        logic              rec_valid;
        logic [15:0]       line;
        logic [3:0]        month;
        logic [13:0]       first_year;
        logic signed [7:0] mon_min;
        logic signed [7:0] mon_max;
        logic signed [7:0] mon_avg;
        logic signed [7:0] all_min;
        logic signed [7:0] all_max;
        logic signed [7:0] all_avg;
        logic [15:0]       total;
    } stats_t;

    // predictor state
    int          cfg_earliest;
    int          cfg_limit;
    int          mon_low [NMONTHS];
    int          mon_high [NMONTHS];
    longint      mon_sum [NMONTHS];
    int          mon_cnt [NMONTHS];
    int          mon_first [NMONTHS];
    int          tot_low;
    int          tot_high;
    longint      tot_sum;
    int          tot_cnt;
    int          next_line;

    stats_t      expected_stats [$];
    int          mismatch_count;
    bit          sender_idles;
    bit          receiver_idles;
    bit          holdoff_req;

    monthly_temperature_statistics uut (.*);

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int trunc_avg(longint sum, int cnt);
        if (cnt == 0)
            return 0;
        return int'(sum / cnt);
    endfunction

    // compute the result of one accepted record and update the statistics
    function automatic stats_t predict_stats(int yr, int mo, int dy, int hr, int mi, int t,
                                             bit complete);
        stats_t r;
        bit     ok;
        int     m;
        ok = complete && yr >= cfg_earliest && yr <= LAST_YEAR && mo >= 1 && mo <= 12
             && dy >= 1 && dy <= 31 && hr <= 23 && mi <= 59
             && t >= -cfg_limit && t <= cfg_limit;
        r = '{default: '0};
        r.line = next_line[15:0];
        next_line = (next_line + 1) & 16'hFFFF;
        if (ok)
        begin
            m = mo - 1;
            if (mon_cnt[m] == 0)
                mon_first[m] = yr;
            if (t < mon_low[m])
                mon_low[m] = t;
            if (t > mon_high[m])
                mon_high[m] = t;
            if (mon_cnt[m] < MAX_RECORDS)
            begin
                mon_sum[m] += t;
                mon_cnt[m]++;
            end
            if (t < tot_low)
                tot_low = t;
            if (t > tot_high)
                tot_high = t;
            if (tot_cnt < MAX_RECORDS)
            begin
                tot_sum += t;
                tot_cnt++;
            end
            r.rec_valid  = 1'b1;
            r.month      = mo[3:0];
            r.first_year = mon_first[m][13:0];
            r.mon_min    = mon_low[m][7:0];
            r.mon_max    = mon_high[m][7:0];
            r.mon_avg    = 8'(trunc_avg(mon_sum[m], mon_cnt[m]));
        end
        r.all_min = tot_low[7:0];
        r.all_max = tot_high[7:0];
        r.all_avg = 8'(trunc_avg(tot_sum, tot_cnt));
        r.total   = tot_cnt[15:0];
        return r;
    endfunction

    // send one record and wait for its transfer
    task automatic send_record(int yr, int mo, int dy, int hr, int mi, int t, bit complete);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        rec_year        <= yr[13:0];
        rec_month       <= mo[3:0];
        rec_day         <= dy[4:0];
        rec_hour        <= hr[4:0];
        rec_minute      <= mi[5:0];
        temperature     <= t[7:0];
        fields_complete <= complete;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_stats.push_back(predict_stats(yr, mo, dy, hr, mi, t, complete));
    endtask

    // a well-formed record with random content, temperature within the limit
    task automatic send_good_record();
        int t;
        t = $urandom_range(0, 2 * cfg_limit) - cfg_limit;
        send_record($urandom_range(cfg_earliest, LAST_YEAR), $urandom_range(1, 12),
                    $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59), t, 1'b1);
    endtask

    // any field value at all
    task automatic send_noise_record();
        send_record($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 63),
                    $urandom_range(0, 255) - 128, $urandom_range(0, 1));
    endtask

    // drop valid at the edge of the last transfer, then drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // apb write: setup then access
    task automatic write_reg(logic idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_EARLIEST_YEAR)
            cfg_earliest = value & 16'h3FFF;
        else
            cfg_limit = value & 8'h7F;
    endtask

    task automatic set_config(int earliest, int limit);
        write_reg(REG_EARLIEST_YEAR, earliest);
        write_reg(REG_TEMP_LIMIT, limit);
    endtask

    // field extremes and each rejection reason
    task automatic test_field_extremes();
        send_record(1972, 1, 1, 0, 0, 0, 1'b1);
        send_record(9999, 12, 31, 23, 59, 99, 1'b1);
        send_record(2000, 12, 31, 23, 59, -99, 1'b1);
        send_record(1971, 3, 5, 5, 5, 10, 1'b1);
        send_record(10000, 3, 5, 5, 5, 10, 1'b1);
        send_record(16383, 15, 31, 31, 63, -128, 1'b0);
        send_record(2000, 0, 5, 5, 5, 10, 1'b1);
        send_record(2000, 13, 5, 5, 5, 10, 1'b1);
        send_record(2000, 3, 0, 5, 5, 10, 1'b1);
        send_record(2000, 3, 5, 24, 5, 10, 1'b1);
        send_record(2000, 3, 5, 5, 60, 10, 1'b1);
        send_record(2000, 3, 5, 5, 5, 100, 1'b1);
        send_record(2000, 3, 5, 5, 5, -100, 1'b1);
        send_record(2000, 3, 5, 5, 5, 10, 1'b0);
        send_record(2001, 3, 5, 5, 5, -7, 1'b1);
        send_record(0, 0, 0, 0, 0, 127, 1'b0);
        wait_idle();
    endtask

    // registers at their extremes, including the -128 reading
    task automatic test_config_extremes();
        set_config(0, 127);
        send_record(0, 6, 1, 0, 0, 127, 1'b1);
        send_record(0, 6, 1, 0, 0, -127, 1'b1);
        send_record(0, 6, 1, 0, 0, -128, 1'b1);
        wait_idle();
        set_config(9999, 0);
        send_record(9999, 7, 2, 1, 1, 0, 1'b1);
        send_record(9999, 7, 2, 1, 1, 1, 1'b1);
        send_record(9998, 7, 2, 1, 1, 0, 1'b1);
        wait_idle();
    endtask

    // random records over several register settings
    task automatic test_random_records(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 250 == 0)
            begin
                wait_idle();
                set_config($urandom_range(0, 4) == 0 ? $urandom_range(0, 9999)
                                                     : $urandom_range(1900, 2100),
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : 99);
            end
            if ($urandom_range(0, 4) == 0)
                send_noise_record();
            else
                send_good_record();
        end
        wait_idle();
    endtask

    // long receiver hold-off while records keep coming
    task automatic test_backpressure();
        holdoff_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_good_record();
        wait_idle();
    endtask

    // steady stream with no idling on either side
    task automatic test_full_rate();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        set_config(1972, 99);
        for (int i = 0; i < 150; i++)
            if ($urandom_range(0, 5) == 0)
                send_noise_record();
            else
                send_good_record();
        wait_idle();
    endtask

    // receiver stall: random bursts or one long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req)
            begin
                out_stall <= 1'b1;
                repeat (700) @(posedge clk);
                out_stall <= 1'b0;
                holdoff_req = 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %0d actual %0d", name, exp_v, act_v);
        end
    endtask

    // compare each result transfer with the oldest prediction
    initial
    begin
        stats_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_stats.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer, line %0d", line_number);
                end
                else
                begin
                    e = expected_stats.pop_front();
                    check_field("record_valid", e.rec_valid, record_valid);
                    check_field("line_number", e.line, line_number);
                    check_field("stats_month", e.month, stats_month);
                    check_field("month_first_year", e.first_year, month_first_year);
                    check_field("month_min", e.mon_min, month_min);
                    check_field("month_max", e.mon_max, month_max);
                    check_field("month_avg", e.mon_avg, month_avg);
                    check_field("year_min", e.all_min, year_min);
                    check_field("year_max", e.all_max, year_max);
                    check_field("year_avg", e.all_avg, year_avg);
                    check_field("valid_total", e.total, valid_total);
                end
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        rec_year = '0;
        rec_month = '0;
        rec_day = '0;
        rec_hour = '0;
        rec_minute = '0;
        temperature = '0;
        fields_complete = 1'b0;
        mismatch_count = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        holdoff_req = 1'b0;
        cfg_earliest = 1972;
        cfg_limit = 99;
        for (int m = 0; m < NMONTHS; m++)
        begin
            mon_low[m] = 99;
            mon_high[m] = -99;
            mon_sum[m] = 0;
            mon_cnt[m] = 0;
            mon_first[m] = 0;
        end
        tot_low = 99;
        tot_high = -99;
        tot_sum = 0;
        tot_cnt = 0;
        next_line = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_config_extremes();
        test_backpressure();
        test_random_records(1250);
        test_full_rate();

        mismatch_count += expected_stats.size();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
sv/mts_pkg.sv
sv/mts_front.sv
sv/mts_queue.sv
sv/mts_div.sv
sv/mts_back.sv
sv/monthly_temperature_statistics.sv
dv/tb_monthly_temperature_statistics.sv
